FILE: rtl/enrs_pkg.sv
// package for the expiring nearest record search block
// shared constants, record type and command codes; no dependencies
`timescale 1ns / 1ps
package enrs_pkg;
    localparam int TableDepth = 16;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);

    typedef enum logic [1:0] {
        CMD_REGISTER = 2'd0,
        CMD_FORGET   = 2'd1,
        CMD_FIND     = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [63:0] id;
        logic [31:0] kind;
        logic [15:0] map_id;
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
        logic [31:0] expiry;
    } record_t;

    localparam int RecW = $bits(record_t);
endpackage

FILE: rtl/enrs_ram.sv
// generic single-port-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module enrs_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/enrs_dist.sv
// squared distance unit: squares registered, then summed
// no dependencies
`timescale 1ns / 1ps
module enrs_dist (
    input  logic                aclk,
    input  logic signed [23:0]  ax, ay, az,
    input  logic signed [23:0]  bx, by, bz,
    output logic        [49:0]  sq_dist
);
    logic signed [24:0] dx, dy, dz;
    logic signed [49:0] px, py, pz;
    logic        [49:0] sx_reg, sy_reg, sz_reg;

    always_comb begin
        dx = 25'(ax) - 25'(bx);
        dy = 25'(ay) - 25'(by);
        dz = 25'(az) - 25'(bz);
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
    end

    always_ff @(posedge aclk) begin
        sx_reg <= $unsigned(px);
        sy_reg <= $unsigned(py);
        sz_reg <= $unsigned(pz);
    end

    assign sq_dist = sx_reg + sy_reg + sz_reg;
endmodule

FILE: rtl/expiring_nearest_record_search.sv
// Expiring nearest record search. Records live in one RAM, packed in
// registration order. forget and find walk the table once (one RAM read per
// entry, compacting in place). One item is worked at a time; the result sits
// in an output register, and the next item is taken once that result has
// been transferred. find drops expired records in the same walk that scores
// the survivors.
`timescale 1ns / 1ps
module expiring_nearest_record_search (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // cmd, record_id, kind, map_id, pos_x, pos_y, pos_z, now_seconds,
    // lifetime_seconds, search_radius, zero fill
    input  logic [279:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // found, found_id, status, zero fill
    output logic [71:0]   m_tdata
);
    import enrs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_DONE = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  rd_reg;      // next entry to read
    logic [CntW-1:0]  wr_reg;      // compaction write pointer
    logic             v1_reg, v2_reg;  // read data / distance stage valid
    logic             keep2_reg, match2_reg;
    logic [63:0]      id2_reg;
    logic [1:0]       cmd_reg;
    logic [63:0]      q_id_reg;
    logic [31:0]      q_kind_reg;
    logic [15:0]      q_map_reg;
    logic [23:0]      q_x_reg, q_y_reg, q_z_reg;
    logic [31:0]      q_now_reg;
    logic [49:0]      best_reg;
    logic [63:0]      best_id_reg;
    logic             hit_reg;
    logic [71:0]      out_reg;
    logic             out_valid_reg;

    logic             we;
    logic [IdxW-1:0]  waddr, raddr;
    record_t          wrec, rrec;
    logic [49:0]      sq_dist;
    logic             keep1, match1;
    logic [32:0]      exp_sum;
    logic [1:0]       in_cmd;
    logic             reg_full;

    assign in_cmd   = s_tdata[1:0];
    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign reg_full = (in_cmd == CMD_REGISTER) && (count_reg >= CntW'(TableDepth));

    enrs_ram #(.Width(RecW), .Depth(TableDepth)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wrec),
        .raddr(raddr), .rdata(rrec)
    );

    enrs_dist u_dist (
        .aclk(aclk),
        .ax(rrec.x), .ay(rrec.y), .az(rrec.z),
        .bx(q_x_reg), .by(q_y_reg), .bz(q_z_reg),
        .sq_dist(sq_dist)
    );

    assign raddr = rd_reg[IdxW-1:0];
    assign exp_sum = {1'b0, s_tdata[217:186]} + {1'b0, s_tdata[249:218]};

    always_comb begin
        if (cmd_reg == CMD_FORGET) begin
            keep1 = rrec.id != q_id_reg;
        end else begin
            keep1 = rrec.expiry > q_now_reg;
        end
        match1 = (rrec.kind == q_kind_reg) && (rrec.map_id == q_map_reg);
    end

    // write port: register append or compaction copy
    always_comb begin
        we    = 1'b0;
        waddr = wr_reg[IdxW-1:0];
        wrec  = rrec;
        if (s_tvalid && s_tready && in_cmd == CMD_REGISTER &&
            count_reg < CntW'(TableDepth)) begin
            we          = 1'b1;
            waddr       = count_reg[IdxW-1:0];
            wrec.id     = s_tdata[65:2];
            wrec.kind   = s_tdata[97:66];
            wrec.map_id = s_tdata[113:98];
            wrec.x      = s_tdata[137:114];
            wrec.y      = s_tdata[161:138];
            wrec.z      = s_tdata[185:162] ;
            wrec.expiry = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
        end else if (state_reg == ST_WALK && v1_reg && keep1) begin
            we = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready) begin
                if (in_cmd == CMD_FORGET || in_cmd == CMD_FIND) begin
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_WALK: if (rd_reg >= count_reg && !v1_reg) state_next = ST_DONE;
            ST_DONE: state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            v1_reg <= (state_reg == ST_WALK) && (rd_reg < count_reg);
            v2_reg <= v1_reg && (state_reg == ST_WALK);
            unique case (state_reg)
                ST_IDLE: if (s_tvalid && s_tready) begin
                    cmd_reg    <= in_cmd;
                    q_id_reg   <= s_tdata[65:2];
                    q_kind_reg <= s_tdata[97:66];
                    q_map_reg  <= s_tdata[113:98];
                    q_x_reg    <= s_tdata[137:114];
                    q_y_reg    <= s_tdata[161:138];
                    q_z_reg    <= s_tdata[185:162];
                    q_now_reg  <= s_tdata[217:186];
                    best_reg   <= 50'(s_tdata[272:250]) * 50'(s_tdata[272:250]);
                    hit_reg    <= 1'b0;
                    best_id_reg <= '0;
                    rd_reg     <= '0;
                    wr_reg     <= '0;
                    // status bit set when a register finds the table full
                    out_reg    <= {6'd0, reg_full, 65'd0};
                    if (in_cmd == CMD_REGISTER && !reg_full) begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                ST_WALK: begin
                    if (rd_reg < count_reg) rd_reg <= rd_reg + 1'b1;
                    if (v1_reg && keep1) wr_reg <= wr_reg + 1'b1;
                    keep2_reg  <= keep1;
                    match2_reg <= match1;
                    id2_reg    <= rrec.id;
                end
                ST_DONE: begin
                    count_reg <= wr_reg;
                    if (cmd_reg == CMD_FIND) begin
                        out_reg <= {7'd0, best_id_reg, hit_reg};
                    end
                end
                ST_OUT: out_valid_reg <= 1'b1;
                default: ;
            endcase
            // score stage, in the cycle after the read data
            if (v2_reg && cmd_reg == CMD_FIND && keep2_reg && match2_reg &&
                sq_dist <= best_reg) begin
                best_reg    <= sq_dist;
                best_id_reg <= id2_reg;
                hit_reg     <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (aresetn) begin
            assert (count_reg <= CntW'(TableDepth))
                else $error("record count past table depth");
        end
    end

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !s_tready) else $error("input taken with result pending");
    a_wr_behind_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> wr_reg <= rd_reg) else $error("compaction overran read");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> !m_tvalid) else $error("result repeated");
endmodule
